>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define CHECK_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CHECK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/sitda_pkg.sv
// package with types and constants of the decimal text converter
package sitda_pkg;

	localparam int unsigned IN_W = 64;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned DIGIT_W = 4;

	// log10(2) as a ratio, for the digit count of a magnitude width
	localparam int unsigned LOG10_2_NUM = 30103;
	localparam int unsigned LOG10_2_DEN = 100000;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_SIGN,
		ST_EMIT
	} back_state_t;

endpackage

>>> rtl/core/sitda_front.sv
// front part: takes integers, splits sign and magnitude, queues them
module sitda_front #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [sitda_pkg::IN_W-1:0]   value,
	output logic                         job_valid,
	input  logic                         job_ready,
	output logic                         job_neg,
	output logic [VALUE_WIDTH-1:0]       job_mag
);

	logic [VALUE_WIDTH-1:0] v;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   push_acc;
	logic                   job_take;

	logic                   neg_mem_q [2];
	logic [VALUE_WIDTH-1:0] mag_mem_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;

	assign v = value[VALUE_WIDTH-1:0];
	assign neg = v[VALUE_WIDTH-1];
	assign mag = neg ? (~v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v;

	assign full = (count_q == 2'd2);
	assign job_valid = (count_q != 2'd0);
	assign push_acc = push && !full;
	assign job_take = job_valid && job_ready;

	assign job_neg = neg_mem_q[rd_ptr_q];
	assign job_mag = mag_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_acc) begin
			neg_mem_q[wr_ptr_q] <= neg;
			mag_mem_q[wr_ptr_q] <= mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push_acc) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (job_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push_acc, job_take})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`include "assert_macros.svh"

	`CHECK_ALWAYS(a_count_range, count_q != 2'd3, "queue count out of range")
	`CHECK_NEXT(a_pop_only, job_take && !push_acc && count_q == 2'd1, count_q == 2'd0, "queue count not drained")

endmodule

>>> rtl/core/sitda_back.sv
// back part: serial shift-add-3 conversion and character emission
module sitda_back #(
	parameter int unsigned VALUE_WIDTH = 64,
	parameter int unsigned NUM_DIGITS = 19
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                job_valid,
	output logic                                job_ready,
	input  logic                                job_neg,
	input  logic [VALUE_WIDTH-1:0]              job_mag,
	output logic                                empty,
	input  logic                                pop,
	output logic [sitda_pkg::CHAR_W-1:0]        text_char,
	output logic                                last
);

	localparam int unsigned DW = sitda_pkg::DIGIT_W;
	localparam int unsigned BCD_W = DW * NUM_DIGITS;
	localparam int unsigned CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
	localparam int unsigned NDIG_W = $clog2(NUM_DIGITS + 1);

	sitda_pkg::back_state_t state_q, state_d;

	logic [BCD_W-1:0]             bcd_q;
	logic [BCD_W-1:0]             bcd_adj;
	logic [VALUE_WIDTH-1:0]       mag_q;
	logic                         neg_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [NDIG_W-1:0]            ndig_q;
	logic [DW-1:0]                top_digit;
	logic                         conv_done;
	logic                         trim_more;
	logic                         slot_free;
	logic                         out_load;
	logic [sitda_pkg::CHAR_W-1:0] out_char_d;
	logic                         out_last_d;
	logic                         out_valid_q;
	logic [sitda_pkg::CHAR_W-1:0] out_char_q;
	logic                         out_last_q;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[i*DW +: DW] = (bcd_q[i*DW +: DW] >= 4'd5) ?
				bcd_q[i*DW +: DW] + 4'd3 : bcd_q[i*DW +: DW];
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: DW];
	assign conv_done = (cnt_q == CNT_W'(VALUE_WIDTH - 1));
	assign trim_more = (top_digit == '0) && (ndig_q > NDIG_W'(1));
	assign slot_free = !out_valid_q || pop;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sitda_pkg::ST_IDLE: begin
				if (job_valid) begin
					state_d = sitda_pkg::ST_CONV;
				end
			end
			sitda_pkg::ST_CONV: begin
				if (conv_done) begin
					state_d = sitda_pkg::ST_TRIM;
				end
			end
			sitda_pkg::ST_TRIM: begin
				if (!trim_more) begin
					state_d = neg_q ? sitda_pkg::ST_SIGN : sitda_pkg::ST_EMIT;
				end
			end
			sitda_pkg::ST_SIGN: begin
				if (slot_free) begin
					state_d = sitda_pkg::ST_EMIT;
				end
			end
			sitda_pkg::ST_EMIT: begin
				if (slot_free && ndig_q == NDIG_W'(1)) begin
					state_d = sitda_pkg::ST_IDLE;
				end
			end
			default: state_d = sitda_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready = 1'b0;
		out_load = 1'b0;
		out_char_d = sitda_pkg::CHAR_ZERO + {{(sitda_pkg::CHAR_W-DW){1'b0}}, top_digit};
		out_last_d = (ndig_q == NDIG_W'(1));
		case (state_q)
			sitda_pkg::ST_IDLE: job_ready = 1'b1;
			sitda_pkg::ST_SIGN: begin
				out_load = slot_free;
				out_char_d = sitda_pkg::CHAR_MINUS;
				out_last_d = 1'b0;
			end
			sitda_pkg::ST_EMIT: out_load = slot_free;
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sitda_pkg::ST_IDLE: begin
				bcd_q <= '0;
				mag_q <= job_mag;
				neg_q <= job_neg;
			end
			sitda_pkg::ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
				mag_q <= mag_q << 1;
			end
			sitda_pkg::ST_TRIM: begin
				if (trim_more) begin
					bcd_q <= bcd_q << DW;
				end
			end
			sitda_pkg::ST_EMIT: begin
				if (out_load) begin
					bcd_q <= bcd_q << DW;
				end
			end
			default: bcd_q <= bcd_q;
		endcase
		if (out_load) begin
			out_char_q <= out_char_d;
			out_last_q <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sitda_pkg::ST_IDLE;
			cnt_q <= '0;
			ndig_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sitda_pkg::ST_IDLE: begin
					cnt_q <= '0;
					ndig_q <= NDIG_W'(NUM_DIGITS);
				end
				sitda_pkg::ST_CONV: cnt_q <= cnt_q + CNT_W'(1);
				sitda_pkg::ST_TRIM: begin
					if (trim_more) begin
						ndig_q <= ndig_q - NDIG_W'(1);
					end
				end
				sitda_pkg::ST_EMIT: begin
					if (out_load) begin
						ndig_q <= ndig_q - NDIG_W'(1);
					end
				end
				default: cnt_q <= cnt_q;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;
	assign text_char = out_char_q;
	assign last = out_last_q;

	`include "assert_macros.svh"

	`CHECK_SAME(a_emit_has_digit, state_q == sitda_pkg::ST_EMIT, ndig_q != '0, "no digit left to emit")
	`CHECK_NEXT(a_last_ends_item, out_load && out_last_d, state_q == sitda_pkg::ST_IDLE, "item not finished after last character")

endmodule

>>> rtl/core/signed_int_to_decimal_ascii_core.sv
// top level: signed integer to decimal ascii text, one character per transaction
// an item is taken from the queue in the cycle after it is pushed, when the back part is idle
// per item: a take, a shift-add-3 pass over the magnitude bits, a trim of the leading zero
// digits, a minus character for a negative value, then the digit characters
// the serial shift-add-3 loop and the one-character output register set the rate
// reset empties the two-entry queue and clears the state machine and the output valid flag
module signed_int_to_decimal_ascii_core #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [sitda_pkg::IN_W-1:0]        value,
	output logic                              empty,
	input  logic                              pop,
	output logic [sitda_pkg::CHAR_W-1:0]      text_char,
	output logic                              last
);

	localparam int unsigned NUM_DIGITS =
		((VALUE_WIDTH - 1) * sitda_pkg::LOG10_2_NUM) / sitda_pkg::LOG10_2_DEN + 1;

	logic                   job_valid;
	logic                   job_ready;
	logic                   job_neg;
	logic [VALUE_WIDTH-1:0] job_mag;

	sitda_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.value(value),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job_neg(job_neg),
		.job_mag(job_mag)
	);

	sitda_back #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NUM_DIGITS(NUM_DIGITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job_neg(job_neg),
		.job_mag(job_mag),
		.empty(empty),
		.pop(pop),
		.text_char(text_char),
		.last(last)
	);

endmodule
